### rtl/core/ciu_pkg.sv
// ----------------------------------------------------------------------------
// ciu_pkg
// Types, codes and reset constants shared by the chunked image upload
// sequencer and its channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package ciu_pkg;

	// default width of the running byte offset
	localparam int unsigned OFFSET_BITS_DEF = 24;

	// register reset values
	localparam logic [31:0] PASSWORD_RST     = 32'h7856_3412;
	localparam logic        START_UNLOCK_RST = 1'b0;
	localparam logic [23:0] MAX_IMAGE_RST    = 24'd65536;

	// well formed password message
	localparam logic [8:0] PW_MSG_LEN   = 9'd9;
	localparam logic [7:0] PW_FRAME_LEN = 8'd4;

	// configuration register word addresses (paddr[3:2])
	localparam logic [1:0] REG_PASSWORD  = 2'd0;
	localparam logic [1:0] REG_START_UNL = 2'd1;
	localparam logic [1:0] REG_MAX_IMAGE = 2'd2;
	localparam int unsigned PADDR_BITS   = 4;

	// request kinds
	localparam logic [1:0] REQ_PASSWORD = 2'd0;
	localparam logic [1:0] REQ_HEADER   = 2'd1;
	localparam logic [1:0] REQ_PAYLOAD  = 2'd2;
	localparam logic [1:0] REQ_OTHER    = 2'd3;

	// header direction codes
	localparam logic [1:0] CR_COMMAND  = 2'd0;
	localparam logic [1:0] CR_RESPONSE = 2'd1;
	localparam logic [1:0] CR_ACK      = 2'd2;

	// reply kinds and status codes
	localparam logic       KIND_PASSWORD = 1'b0;
	localparam logic       KIND_FINAL    = 1'b1;
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_BAD_REQ    = 2'd1;
	localparam logic [1:0] ST_DEFAULT    = 2'd2;

	typedef enum logic [1:0] {
		PH_NEVER   = 2'd0,
		PH_ONGOING = 2'd1,
		PH_FAILED  = 2'd2
	} phase_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [8:0]  msg_len;
		logic [1:0]  cmd_resp;
		logic        error_flag;
		logic        chained;
		logic [15:0] chunk_number;
		logic [15:0] chunk_total;
		logic [23:0] image_length;
		logic [7:0]  frame_length;
		logic [31:0] presented_password;
		logic [7:0]  data_byte;
	} req_t;

	typedef struct packed {
		logic        flash_write;
		logic [23:0] flash_offset;
		logic [31:0] flash_word;
		logic        erase_request;
		logic        reply_valid;
		logic        reply_kind;
		logic [1:0]  reply_status;
		logic [23:0] bytes_done;
		logic        session_end;
		logic [1:0]  update_status;
	} rsp_t;

endpackage

`default_nettype wire

### rtl/core/ciu_req_if.sv
// ----------------------------------------------------------------------------
// ciu_req_if
// Valid/ready channel carrying one decoded mailbox item per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ciu_req_if;
	import ciu_pkg::*;

	logic valid;
	logic ready;
	req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/core/ciu_rsp_if.sv
// ----------------------------------------------------------------------------
// ciu_rsp_if
// Valid/ready channel carrying one result beat per accepted item.
// ----------------------------------------------------------------------------
`default_nettype none

interface ciu_rsp_if;
	import ciu_pkg::*;

	logic valid;
	logic ready;
	rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/core/chunked_image_upload_sequencer.sv
// ----------------------------------------------------------------------------
// chunked_image_upload_sequencer
// Password check, chunk header validation and payload word packing for a
// mailbox driven firmware image upload.
// ----------------------------------------------------------------------------
// Usage:
//   req  : decoded mailbox items (password message, chunk header, payload
//          byte, other). Every accepted beat yields exactly one rsp beat.
//   rsp  : flash write strobe/offset/word, erase request, reply strobe with
//          kind and status, running byte count, session end pulse and the
//          update phase after the item.
//   APB  : stored_password at 0x0, start_unlocked at 0x4, max_image_bytes at
//          0x8. Writing start_unlocked also reloads the unlock flag. Write
//          only while no result is pending.
// The result of a beat accepted at an edge is held in the result register
// from that edge on. Throughput is one item per cycle unless rsp stalls; all
// bookkeeping is updated by a single compare/pack pass on the accepted beat.
// req.ready is low only while the result register is full and rsp.ready is
// low, so a stalled receiver holds the current result and back-pressures
// one item. Reset clears all bookkeeping, loads the register defaults and
// leaves the result register empty.
// ----------------------------------------------------------------------------
`default_nettype none

module chunked_image_upload_sequencer #(
	parameter int unsigned OFFSET_BITS = ciu_pkg::OFFSET_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	ciu_req_if.sink                              req,
	ciu_rsp_if.source                            rsp,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [ciu_pkg::PADDR_BITS-1:0] paddr,
	input  wire logic [31:0]                     pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready
);
	import ciu_pkg::*;

	localparam int unsigned EXT_BITS = OFFSET_BITS + 24;

	// configuration registers
	logic [31:0] password_q;
	logic        start_unl_q;
	logic [23:0] max_image_q;

	// bookkeeping
	logic                   unlocked_q,   unlocked_d;
	phase_t                 phase_q,      phase_d;
	logic [15:0]            seen_q,       seen_d;
	logic [15:0]            final_q,      final_d;
	logic [15:0]            current_q,    current_d;
	logic [23:0]            expected_q,   expected_d;
	logic [OFFSET_BITS-1:0] written_q,    written_d;
	logic [31:0]            pword_q,      pword_d;
	logic [2:0]             fill_q,       fill_d;
	logic [7:0]             left_q,       left_d;

	// result register
	logic rsp_vld_q;
	rsp_t rsp_s1;
	rsp_t res;

	logic acc;
	logic cfg_wr;
	logic first;
	logic bad;

	function automatic logic [23:0] low24(input logic [OFFSET_BITS-1:0] v);
		logic [EXT_BITS-1:0] e;
		e = {24'd0, v};
		return e[23:0];
	endfunction

	function automatic logic same_len(input logic [OFFSET_BITS-1:0] w,
	                                  input logic [23:0] x);
		logic [EXT_BITS-1:0] ew;
		logic [EXT_BITS-1:0] ex;
		ew = {24'd0, w};
		ex = {{OFFSET_BITS{1'b0}}, x};
		return ew == ex;
	endfunction

	assign req.ready = !rsp_vld_q || rsp.ready;
	assign acc       = req.valid && req.ready;
	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && pready;

	// register read mux
	always_comb begin
		unique case (paddr[3:2])
			REG_PASSWORD:  prdata = password_q;
			REG_START_UNL: prdata = {31'd0, start_unl_q};
			REG_MAX_IMAGE: prdata = {8'd0, max_image_q};
			default:       prdata = 32'd0;
		endcase
	end

	// one pass over the accepted item
	always_comb begin
		unlocked_d = unlocked_q;
		phase_d    = phase_q;
		seen_d     = seen_q;
		final_d    = final_q;
		current_d  = current_q;
		expected_d = expected_q;
		written_d  = written_q;
		pword_d    = pword_q;
		fill_d     = fill_q;
		left_d     = left_q;
		res        = '0;
		first      = 1'b0;
		bad        = 1'b0;

		case (req.payload.req_type)
			REQ_PAYLOAD: begin
				if (left_q != 8'd0) begin
					pword_d = pword_q | ({24'd0, req.payload.data_byte} << {fill_q[1:0], 3'b000});
					fill_d  = fill_q + 3'd1;
					if (fill_d[2]) begin
						res.flash_write  = 1'b1;
						res.flash_offset = low24(written_q);
						res.flash_word   = pword_d;
						written_d        = written_q + OFFSET_BITS'(4);
						pword_d          = '0;
						fill_d           = '0;
					end
					left_d = left_q - 8'd1;
				end
			end
			REQ_PASSWORD: begin
				left_d = '0;
				if (req.payload.msg_len == PW_MSG_LEN && req.payload.cmd_resp == CR_RESPONSE &&
				    !req.payload.error_flag && !req.payload.chained &&
				    req.payload.frame_length == PW_FRAME_LEN) begin
					unlocked_d        = (req.payload.presented_password == password_q);
					res.reply_valid   = 1'b1;
					res.reply_kind    = KIND_PASSWORD;
					res.reply_status  = unlocked_d ? ST_OK : ST_BAD_REQ;
					res.session_end   = unlocked_q && !unlocked_d;
				end
			end
			REQ_HEADER: begin
				left_d = '0;
				if (unlocked_q) begin
					if (req.payload.cmd_resp == CR_ACK) begin
						res.session_end = !req.payload.error_flag;
					end else begin
						first = (req.payload.chunk_number == 16'd1);
						bad   = req.payload.cmd_resp != CR_COMMAND || !req.payload.chained ||
						        req.payload.chunk_number > req.payload.chunk_total;
						if (!first)
							bad = bad ||
							      ({1'b0, req.payload.chunk_number} != ({1'b0, seen_q} + 17'd1)) ||
							      req.payload.image_length != expected_q ||
							      req.payload.chunk_total != final_q ||
							      phase_q != PH_ONGOING;
						else
							bad = bad || req.payload.image_length > max_image_q;
						// restart bookkeeping
						if (bad || first) begin
							written_d  = '0;
							expected_d = req.payload.image_length;
							seen_d     = '0;
							final_d    = req.payload.chunk_total;
							fill_d     = '0;
							pword_d    = '0;
						end
						if (bad) begin
							phase_d = (phase_q != PH_NEVER) ? PH_FAILED : PH_NEVER;
						end else begin
							if (first) begin
								res.erase_request = 1'b1;
								phase_d           = PH_ONGOING;
							end
							seen_d    = seen_d + 16'd1;
							current_d = req.payload.chunk_number;
							left_d    = req.payload.frame_length;
						end
					end
				end
			end
			default: begin
				left_d = '0;
			end
		endcase

		// end of chunk: flush pending bytes and give the final reply on the last one
		if (left_d == 8'd0 && current_d == final_d &&
		    ((req.payload.req_type == REQ_PAYLOAD && left_q != 8'd0) ||
		     (req.payload.req_type == REQ_HEADER && unlocked_q &&
		      req.payload.cmd_resp != CR_ACK && !bad))) begin
			if (fill_d != 3'd0) begin
				res.flash_write  = 1'b1;
				res.flash_offset = low24(written_d);
				res.flash_word   = pword_d;
				written_d        = written_d + OFFSET_BITS'(fill_d);
				pword_d          = '0;
				fill_d           = '0;
			end
			res.reply_valid  = 1'b1;
			res.reply_kind   = KIND_FINAL;
			res.reply_status = same_len(written_d, expected_d) ? ST_OK : ST_DEFAULT;
			phase_d          = PH_FAILED;
		end

		res.bytes_done    = low24(written_d);
		res.update_status = phase_d;
	end

	// configuration and bookkeeping state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			password_q  <= PASSWORD_RST;
			start_unl_q <= START_UNLOCK_RST;
			max_image_q <= MAX_IMAGE_RST;
			unlocked_q  <= START_UNLOCK_RST;
			phase_q     <= PH_NEVER;
			seen_q      <= '0;
			final_q     <= '0;
			current_q   <= '0;
			expected_q  <= '0;
			written_q   <= '0;
			pword_q     <= '0;
			fill_q      <= '0;
			left_q      <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_PASSWORD:  password_q <= pwdata;
				REG_START_UNL: begin
					start_unl_q <= pwdata[0];
					unlocked_q  <= pwdata[0];
				end
				REG_MAX_IMAGE: max_image_q <= pwdata[23:0];
				default:       ;
			endcase
		end else if (acc) begin
			unlocked_q <= unlocked_d;
			phase_q    <= phase_d;
			seen_q     <= seen_d;
			final_q    <= final_d;
			current_q  <= current_d;
			expected_q <= expected_d;
			written_q  <= written_d;
			pword_q    <= pword_d;
			fill_q     <= fill_d;
			left_q     <= left_d;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (acc) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (acc) begin
			rsp_s1 <= res;
		end
	end

	assign rsp.valid   = rsp_vld_q;
	assign rsp.payload = rsp_s1;

	// payload bytes are only expected inside a running update
	a_left_ongoing: assert property (@(posedge clk) disable iff (!arst_n)
		left_q != 8'd0 |-> phase_q == PH_ONGOING)
		else $error("payload pending outside an ongoing update");

	// the packer never holds a full word
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 3'd3)
		else $error("partial word fill out of range");

	// a first chunk restarts the packer, so it never writes in the same beat
	a_erase_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_vld_q && rsp_s1.erase_request |-> !rsp_s1.flash_write)
		else $error("erase and flash write in one result");

	// every accepted item produces a result
	a_acc_result: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> rsp_vld_q)
		else $error("accepted item without result");

	// a final reply always leaves the update marked failed/closed
	a_final_closes: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_vld_q && rsp_s1.reply_valid && rsp_s1.reply_kind == KIND_FINAL
		|-> rsp_s1.update_status == PH_FAILED)
		else $error("final reply without closing the update");

endmodule

`default_nettype wire
